@@ design/assert_macros.svh @@
// Assertion macros used by the port checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define FX_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/fx20_pkg.sv @@
// Types, codes and helper functions of the 12.20 fixed-point multiply/divide unit.
package fx20_pkg;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;
	localparam logic [1:0] OP_DEC = 2'd2;
	localparam logic [1:0] OP_UNDEF = 2'd3;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam int DIV_STAGES = 8;
	localparam int DIV_STEPS = 4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] first_operand;
		logic [31:0] second_operand;
	} in_t;

	typedef struct packed {
		logic [31:0] result;
		logic        invalid;
	} out_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        op;
		logic              bad;
		logic signed [7:0] sh;
		logic [31:0]       val;
		logic [15:0]       rem;
		logic [31:0]       qn;
		logic [15:0]       den;
	} div_t;

	// Leading zero count; zero for a zero word.
	function automatic logic [4:0] clz32(input logic [31:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) n = 5'(31 - i);
		end
		return n;
	endfunction

	// Trailing zero count of a 17-bit value; zero for a zero value.
	function automatic logic [4:0] tz17(input logic [16:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 16; i >= 0; i--) begin
			if (v[i]) n = 5'(i);
		end
		return n;
	endfunction

	// Positive amounts shift left, negative right; 32 or more gives zero.
	function automatic logic [31:0] sshift(input logic [31:0] v, input logic signed [7:0] sh);
		logic [31:0] r;
		logic signed [7:0] neg;
		neg = -sh;
		if (sh >= 8'sd32 || sh <= -8'sd32) r = '0;
		else if (sh >= 8'sd0) r = v << sh[4:0];
		else r = v >> neg[4:0];
		return r;
	endfunction

	// Four restoring divide steps on one pipeline stage.
	function automatic div_t div_step(input div_t d);
		div_t o;
		logic [16:0] r17;
		o = d;
		for (int k = 0; k < DIV_STEPS; k++) begin
			r17 = {o.rem, o.qn[31]};
			if (r17 >= {1'b0, o.den}) begin
				o.rem = 16'(r17 - {1'b0, o.den});
				o.qn = {o.qn[30:0], 1'b1};
			end else begin
				o.rem = r17[15:0];
				o.qn = {o.qn[30:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage

@@ design/fx20_fixed_point_mul_div_top.sv @@
// Top level of the 12.20 fixed-point multiply, divide and code decode pipeline.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_data  (opcode, first_operand, second_operand)
//  out       output     out_valid / out_ready  out_data (result, invalid)
//
// One transfer enters per cycle while the output is not stalled; each result shows on out_valid
// after its input transfer has passed through thirteen register stages, eight of them the
// restoring divider (four quotient bits per stage).
// Only the valid bits and the divider stage records are reset by arst_n; the other data registers are not.
// When a result waits on out_ready, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
module fx20_fixed_point_mul_div_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fx20_pkg::in_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output fx20_pkg::out_t out_data
);
	import fx20_pkg::*;

	logic en;

	// Stage 1 registers.
	logic              v_s1, bad_s1;
	logic [1:0]        op_s1;
	logic [31:0]       a_s1, b_s1, dec_s1;
	logic [4:0]        lza_s1, lzb_s1;
	// Stage 2 registers.
	logic              v_s2, bad_s2;
	logic [1:0]        op_s2;
	logic [31:0]       dec_s2;
	logic [16:0]       ma_s2, mb_s2;
	logic [4:0]        lza_s2, lzb_s2;
	// Stage 3 registers.
	logic              v_s3, bad_s3;
	logic [1:0]        op_s3;
	logic [31:0]       dec_s3;
	logic signed [7:0] sh_s3;
	logic [15:0]       n16_s3, odda_s3, oddb_s3;
	// Divider stages; entry k is pipeline stage 4 + k.
	div_t              dv_s [DIV_STAGES + 1];
	// Output stage.
	logic              out_valid_s13;
	out_t              out_data_s13;

	assign en = !out_valid_s13 || out_ready;
	assign in_ready = en;
	assign out_valid = out_valid_s13;
	assign out_data = out_data_s13;

	// Input side: bad operand checks and the factory code decode.
	logic        bad_in;
	logic [11:0] code;
	logic [31:0] dec_in;
	always_comb begin
		code = in_data.first_operand[11:0];
		bad_in = (in_data.opcode == OP_DIV && (in_data.first_operand == ALL_ONES ||
			in_data.second_operand == ALL_ONES || in_data.second_operand == '0)) ||
			(in_data.opcode != OP_MUL && in_data.opcode != OP_DIV && in_data.opcode != OP_DEC);
		if (code == '0) dec_in = '0;
		else dec_in = {23'd0, 1'b1, code[7:0]} << (5'(code[11:8]) + 5'd3);
	end

	// Rounding to 16 significant bits in normalized form.
	logic [31:0] na, nb;
	logic [16:0] ma, mb;
	logic        ovf;
	always_comb begin
		na = a_s1 << lza_s1;
		nb = b_s1 << lzb_s1;
		ma = {1'b0, na[31:16]} + {16'd0, na[15]};
		mb = {1'b0, nb[31:16]} + {16'd0, nb[15]};
		ovf = (op_s1 == OP_MUL || op_s1 == OP_DIV) &&
			((lza_s1 == '0 && ma[16]) || (lzb_s1 == '0 && mb[16]));
	end

	// Odd parts, normalized dividend and the rescaling shift.
	logic [4:0]        tza, tzb, nsh;
	logic [15:0]       odda, oddb, n16;
	logic signed [7:0] sa, sb, sh;
	always_comb begin
		tza = tz17(ma_s2);
		tzb = tz17(mb_s2);
		odda = 16'(ma_s2 >> tza);
		oddb = 16'(mb_s2 >> tzb);
		// A rounding carry makes the value a single one bit one place higher.
		if (ma_s2[16]) begin
			nsh = lza_s2 - 5'd1;
			n16 = 16'h8000;
		end else begin
			nsh = lza_s2;
			n16 = ma_s2[15:0];
		end
		sa = 8'sd16 + $signed({3'b000, tza}) - $signed({3'b000, lza_s2});
		sb = 8'sd16 + $signed({3'b000, tzb}) - $signed({3'b000, lzb_s2});
		if (op_s2 == OP_DIV) sh = 8'sd20 - $signed({3'b000, nsh}) - sb;
		else sh = sa + sb - 8'sd20;
	end

	// Multiply and divider entry.
	div_t dv_in;
	always_comb begin
		dv_in.vld = v_s3;
		dv_in.op = op_s3;
		dv_in.bad = bad_s3;
		dv_in.sh = sh_s3;
		dv_in.val = (op_s3 == OP_DEC) ? dec_s3 : odda_s3 * oddb_s3;
		dv_in.rem = '0;
		dv_in.qn = {n16_s3, 16'd0};
		dv_in.den = oddb_s3;
	end

	// Final rescaling and result select.
	div_t  dl;
	out_t  fin;
	always_comb begin
		dl = dv_s[DIV_STAGES];
		if (dl.bad) fin.result = ALL_ONES;
		else if (dl.op == OP_DEC) fin.result = dl.val;
		else if (dl.op == OP_DIV) fin.result = sshift(dl.qn, dl.sh);
		else fin.result = sshift(dl.val, dl.sh);
		fin.invalid = dl.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_s13 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid_s13 <= dv_s[DIV_STAGES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_data.opcode;
			a_s1 <= in_data.first_operand;
			b_s1 <= in_data.second_operand;
			lza_s1 <= clz32(in_data.first_operand);
			lzb_s1 <= clz32(in_data.second_operand);
			bad_s1 <= bad_in;
			dec_s1 <= dec_in;

			op_s2 <= op_s1;
			bad_s2 <= bad_s1 || ovf;
			dec_s2 <= dec_s1;
			ma_s2 <= ma;
			mb_s2 <= mb;
			lza_s2 <= lza_s1;
			lzb_s2 <= lzb_s1;

			op_s3 <= op_s2;
			bad_s3 <= bad_s2;
			dec_s3 <= dec_s2;
			sh_s3 <= sh;
			n16_s3 <= n16;
			odda_s3 <= odda;
			oddb_s3 <= oddb;

			out_data_s13 <= fin;
		end
	end

	// The divider stage records are reset whole, their valid bits included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) dv_s[k] <= '0;
		end else if (en) begin
			dv_s[0] <= dv_in;
			for (int k = 1; k <= DIV_STAGES; k++) dv_s[k] <= div_step(dv_s[k - 1]);
		end
	end

endmodule

@@ design/fx20_chk.sv @@
// Port checker for the fixed-point multiply/divide pipeline, bound to the top level.
`include "assert_macros.svh"

module fx20_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input fx20_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input fx20_pkg::out_t out_data
);
	import fx20_pkg::*;

	// A waiting result must hold until its transfer.
	`FX_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
	// A flagged result always reads as all ones.
	`FX_ASSERT(a_bad_ones, clk, arst_n, out_valid && out_data.invalid |-> out_data.result == ALL_ONES, "invalid result not all ones")
	// The input side only stalls behind a result that is not taken.
	`FX_ASSERT(a_ready_stall, clk, arst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")
	// Nothing comes out in the cycle after reset ends.
	`FX_ASSERT_ALWAYS(a_reset_empty, clk, !$past(arst_n) |-> !out_valid, "result shown right after reset")

endmodule

bind fx20_fixed_point_mul_div_top fx20_chk u_fx20_chk (.*);

@@ test/fx20_result_checker.sv @@
// Result checker for the 12.20 fixed-point multiply/divide unit: predicts and compares.
`timescale 1ns / 1ps
module fx20_result_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  fx20_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  fx20_pkg::out_t out_data,
	output int             errors,
	output int             pending,
	output int             n_results,
	output int             n_invalid
);
	import fx20_pkg::*;

	out_t expected_q[$];

	function automatic int lead_count(input logic [31:0] v);
		int n;
		n = 0;
		if (v == 0) return 0;
		while (!v[31]) begin
			v = v << 1;
			n++;
		end
		return n;
	endfunction

	function automatic int trail_count(input logic [31:0] v);
		int n;
		n = 0;
		if (v == 0) return 0;
		while (!v[0]) begin
			v = v >> 1;
			n++;
		end
		return n;
	endfunction

	function automatic logic [31:0] scale(input logic [31:0] v, input int amt);
		if (amt >= 32 || amt <= -32) return '0;
		if (amt >= 0) return v << amt;
		return v >> (-amt);
	endfunction

	// Rounds to 16 significant bits; returns 0 when the rounding would overflow.
	function automatic bit round_sig16(input logic [31:0] v, output logic [31:0] r);
		int lz;
		logic [31:0] n;
		lz = lead_count(v);
		n = v << lz;
		r = '0;
		if ((n & 32'hFFFF8000) == 32'hFFFF8000) begin
			if (lz == 0) return 0;
			r = 32'h80000000 >> (lz - 1);
			return 1;
		end
		n = (n + 32'h00008000) & 32'hFFFF0000;
		r = n >> lz;
		return 1;
	endfunction

	function automatic out_t fx_compute(input in_t it);
		out_t o;
		logic [31:0] ra, rb, den, code;
		int sa, sb;
		bit ok;
		ok = 0;
		o.result = '0;
		case (it.opcode)
			OP_MUL: begin
				if (round_sig16(it.first_operand, ra) && round_sig16(it.second_operand, rb)) begin
					sa = trail_count(ra);
					sb = trail_count(rb);
					ra = ra >> sa;
					rb = rb >> sb;
					o.result = scale({16'd0, ra[15:0]} * {16'd0, rb[15:0]}, -20 + sa + sb);
					ok = 1;
				end
			end
			OP_DIV: begin
				if (it.first_operand != ALL_ONES && it.second_operand != ALL_ONES
						&& it.second_operand != 0
						&& round_sig16(it.first_operand, ra)
						&& round_sig16(it.second_operand, rb)) begin
					sa = lead_count(ra);
					ra = ra << sa;
					sb = trail_count(rb);
					rb = rb >> sb;
					den = {16'd0, rb[15:0]};
					if (den != 0) begin
						o.result = scale(ra / den, 20 - sa - sb);
						ok = 1;
					end
				end
			end
			OP_DEC: begin
				code = it.first_operand & 32'h0FFF;
				if (code != 0)
					o.result = ((code & 32'h00FF) | 32'h0100) << (((code & 32'h0F00) >> 8) + 3);
				ok = 1;
			end
			default: ok = 0;
		endcase
		if (!ok) o.result = ALL_ONES;
		o.invalid = !ok;
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			errors <= 0;
			n_results <= 0;
			n_invalid <= 0;
		end else begin
			if (in_valid && in_ready) expected_q.push_back(fx_compute(in_data));
			if (out_valid && out_ready) begin
				n_results <= n_results + 1;
				if (out_data.invalid) n_invalid <= n_invalid + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result transfer: expected none, actual %h/%b",
						$time, out_data.result, out_data.invalid);
					errors <= errors + 1;
				end else begin
					want = expected_q.pop_front();
					if (want.result !== out_data.result || want.invalid !== out_data.invalid) begin
						$display("%0t: mismatch: expected result %h invalid %b, actual %h %b",
							$time, want.result, want.invalid, out_data.result, out_data.invalid);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

@@ test/tb_fx20_fixed_point_mul_div_top.sv @@
// Testbench top for the 12.20 fixed-point multiply/divide unit: stimulus and verdict.
`timescale 1ns / 1ps
module tb_fx20_fixed_point_mul_div_top;
	import fx20_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_t out_data;
	int errors, pending, n_results, n_invalid;
	bit calm = 0;

	always #10 clk = ~clk;

	fx20_fixed_point_mul_div_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	fx20_result_checker i_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .errors(errors), .pending(pending),
		.n_results(n_results), .n_invalid(n_invalid)
	);

	// Receiver stalls at random except in the calm stretch.
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 36);

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'hFFFFFFFF;
			1: return 32'hFFFF8000 + $urandom_range(32'h7FFF);
			2: return 32'h0;
			3: return 32'h1 << $urandom_range(31);
			4: return $urandom_range(32'hFFFF);
			5: return 32'h00100000 + $urandom_range(32'h3FFFFF);
			6: return {16'($urandom_range(32'hFFFF)), 16'h8000} | $urandom_range(32'h7FFF);
			default: return $urandom;
		endcase
	endfunction

	// Holds one transfer on the input channel until it is accepted.
	task automatic send_op(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{opcode: op, first_operand: a, second_operand: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin
		logic [1:0] op;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_op(OP_MUL, 32'h00100000, 32'h00100000);
		send_op(OP_MUL, 32'h0, 32'h12345678);
		send_op(OP_MUL, 32'hFFFF8000, 32'h00100000);
		send_op(OP_MUL, 32'hFFFF7FFF, 32'hFFFF7FFF);
		send_op(OP_MUL, 32'h1, 32'h1);
		send_op(OP_MUL, 32'h0001FFFF, 32'h00018001);
		send_op(OP_DIV, 32'h00100000, 32'h00100000);
		send_op(OP_DIV, 32'hFFFFFFFF, 32'h00100000);
		send_op(OP_DIV, 32'h00100000, 32'hFFFFFFFF);
		send_op(OP_DIV, 32'h00100000, 32'h0);
		send_op(OP_DIV, 32'h0, 32'h00300000);
		send_op(OP_DIV, 32'hFFFF8000, 32'h1);
		send_op(OP_DIV, 32'hFFFF7FFF, 32'h1);
		send_op(OP_DIV, 32'h1, 32'hFFFF7FFF);
		send_op(OP_DIV, 32'h7FFFC000, 32'h00000003);
		send_op(OP_DEC, 32'h0, 32'h0);
		send_op(OP_DEC, 32'hFFFFF000, 32'hFFFFFFFF);
		send_op(OP_DEC, 32'h00000FFF, 32'h0);
		send_op(OP_DEC, 32'h00000001, 32'h5);
		send_op(OP_UNDEF, 32'h00100000, 32'h00100000);
		send_op(OP_UNDEF, 32'hFFFFFFFF, 32'h0);
		for (int i = 0; i < 550; i++) begin
			calm = (i >= 200 && i < 280);
			op = ($urandom_range(19) == 0) ? OP_UNDEF : 2'($urandom_range(2));
			send_op(op, (op == OP_DEC && $urandom_range(1)) ? $urandom_range(32'hFFF)
				: pick_operand(), pick_operand());
		end
		in_valid <= 0;
		calm = 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("Checked %0d results over multiply, divide, decode and undefined opcodes,",
			n_results);
		$display("%0d of them flagged invalid, with random stalls on both channels.", n_invalid);
		if (errors == 0)
			$display("** fx20_fixed_point_mul_div_top: PASSED **");
		else
			$display("** fx20_fixed_point_mul_div_top: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still outstanding.", pending);
		$display("** fx20_fixed_point_mul_div_top: FAILED **");
		$finish;
	end
endmodule
